>>> rtl/core/mcc_pkg.sv
// shared types, code tables and lookup functions of the morse codec
`timescale 1ns / 1ps

package mcc_pkg;

    localparam int MAX_CODE_LEN   = 8;
    localparam int TABLE_SIZE     = 44;
    localparam int ENCODE_ENTRIES = 43;
    localparam int FIFO_DEPTH     = 4;

    localparam int LEN_W = $clog2(MAX_CODE_LEN + 1);
    localparam int PAT_W = MAX_CODE_LEN;

    // result kinds on the output channel
    localparam logic [2:0] KIND_DOT     = 3'd0;
    localparam logic [2:0] KIND_DASH    = 3'd1;
    localparam logic [2:0] KIND_SLASH   = 3'd2;
    localparam logic [2:0] KIND_GAP     = 3'd3;
    localparam logic [2:0] KIND_NEWLINE = 3'd4;
    localparam logic [2:0] KIND_CHAR    = 3'd5;

    // job kinds in the queue between front and back
    localparam logic [1:0] JOB_SYM   = 2'd0;
    localparam logic [1:0] JOB_SLASH = 2'd1;
    localparam logic [1:0] JOB_NL    = 2'd2;
    localparam logic [1:0] JOB_CHAR  = 2'd3;

    typedef struct packed {
        logic [1:0]       kind;
        logic [PAT_W-1:0] pat;
        logic [LEN_W-1:0] len;
        logic [7:0]       ch;
    } t_job;

    typedef struct packed {
        logic             hit;
        logic             slash;
        logic [PAT_W-1:0] pat;
        logic [LEN_W-1:0] len;
    } t_enc_hit;

    typedef struct packed {
        logic       hit;
        logic [7:0] ch;
    } t_dec_hit;

    // bit i is symbol i, 1 = dash; the space entry has length 0 and never decodes
    localparam logic [PAT_W-1:0] SYM_PAT [TABLE_SIZE] = '{
        8'h02, 8'h01, 8'h05, 8'h01, 8'h00, 8'h04, 8'h03, 8'h00, 8'h00, 8'h0E,
        8'h05, 8'h02, 8'h03, 8'h01, 8'h07, 8'h06, 8'h0B, 8'h02, 8'h00, 8'h01,
        8'h04, 8'h08, 8'h06, 8'h09, 8'h0D, 8'h03, 8'h1F, 8'h1E, 8'h1C, 8'h18,
        8'h10, 8'h00, 8'h01, 8'h03, 8'h07, 8'h0F, 8'h00, 8'h2A, 8'h33, 8'h0C,
        8'h07, 8'h21, 8'h00, 8'h04
    };

    localparam logic [LEN_W-1:0] SYM_LEN [TABLE_SIZE] = '{
        4'd2, 4'd4, 4'd4, 4'd3, 4'd1, 4'd4, 4'd3, 4'd4, 4'd2, 4'd4,
        4'd3, 4'd4, 4'd2, 4'd2, 4'd3, 4'd4, 4'd4, 4'd3, 4'd3, 4'd1,
        4'd3, 4'd4, 4'd3, 4'd4, 4'd4, 4'd4, 4'd5, 4'd5, 4'd5, 4'd5,
        4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd0, 4'd6, 4'd6, 4'd6,
        4'd6, 4'd6, 4'd8, 4'd6
    };

    localparam logic [7:0] SYM_CHR [TABLE_SIZE] = '{
        8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68, 8'h69, 8'h6A,
        8'h6B, 8'h6C, 8'h6D, 8'h6E, 8'h6F, 8'h70, 8'h71, 8'h72, 8'h73, 8'h74,
        8'h75, 8'h76, 8'h77, 8'h78, 8'h79, 8'h7A, 8'h30, 8'h31, 8'h32, 8'h33,
        8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h20, 8'h2E, 8'h2C, 8'h3F,
        8'h3A, 8'h2D, 8'h23, 8'h2A
    };

    localparam int SLASH_ENTRY = 36;

    function automatic t_enc_hit enc_lookup(input logic [7:0] b);
        t_enc_hit r;
        r = '0;
        for (int j = 0; j < ENCODE_ENTRIES; j++) begin
            if (SYM_CHR[j] == b) begin
                r.hit   = 1'b1;
                r.slash = (j == SLASH_ENTRY);
                r.pat   = SYM_PAT[j];
                r.len   = SYM_LEN[j];
            end
        end
        return r;
    endfunction

    function automatic t_dec_hit dec_lookup(input logic [PAT_W-1:0] pat,
                                            input logic [LEN_W-1:0] len);
        t_dec_hit r;
        r = '0;
        for (int j = 0; j < TABLE_SIZE; j++) begin
            if (SYM_LEN[j] != '0 && SYM_LEN[j] == len && SYM_PAT[j] == pat) begin
                r.hit = 1'b1;
                r.ch  = SYM_CHR[j];
            end
        end
        return r;
    endfunction

endpackage

>>> rtl/core/mcc_fifo.sv
// job queue between the front and back of the morse codec
`timescale 1ns / 1ps

module mcc_fifo (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  mcc_pkg::t_job i_data,
    input  logic         i_pop,
    output mcc_pkg::t_job o_data,
    output logic         o_empty,
    output logic         o_full
);

    localparam int PTR_W = $clog2(mcc_pkg::FIFO_DEPTH);
    localparam int CNT_W = $clog2(mcc_pkg::FIFO_DEPTH + 1);

    mcc_pkg::t_job r_mem [mcc_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    logic do_push;
    logic do_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CNT_W'(mcc_pkg::FIFO_DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

>>> rtl/core/mcc_front.sv
// front end: takes input words, encodes by table or collects decode tokens, queues jobs
`timescale 1ns / 1ps

module mcc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_direction,
    input  logic          i_valid,
    input  logic [7:0]    i_in_byte,
    input  logic          i_final_req,
    output logic          o_ready,
    input  logic          i_q_full,
    output logic          o_push,
    output mcc_pkg::t_job o_job
);

    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NL    = 8'h0A;

    localparam int PAT_W = mcc_pkg::PAT_W;
    localparam int LEN_W = mcc_pkg::LEN_W;
    localparam int IDX_W = $clog2(PAT_W);

    logic [PAT_W-1:0] r_pat,   n_pat;
    logic [LEN_W-1:0] r_len,   n_len;
    logic             r_slash, n_slash;
    logic             r_inval, n_inval;

    logic              accept;
    logic              flush;
    mcc_pkg::t_enc_hit enc;
    mcc_pkg::t_dec_hit dec;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && !i_q_full;

    always_comb begin
        enc = mcc_pkg::enc_lookup(i_in_byte);

        // token update for this symbol byte
        n_pat   = r_pat;
        n_len   = r_len;
        n_slash = r_slash;
        n_inval = r_inval;
        flush   = 1'b0;
        if (i_in_byte == CH_DOT || i_in_byte == CH_DASH) begin
            if (r_slash || r_len >= LEN_W'(mcc_pkg::MAX_CODE_LEN)) begin
                n_inval = 1'b1;
            end else begin
                if (i_in_byte == CH_DASH) begin
                    n_pat = r_pat | (PAT_W'(1) << r_len[IDX_W-1:0]);
                end
                n_len = r_len + 1'b1;
            end
        end else if (i_in_byte == CH_SLASH) begin
            if (r_len == '0 && !r_slash) begin
                n_slash = 1'b1;
            end else begin
                n_inval = 1'b1;
            end
        end else if (i_in_byte == CH_SPACE || i_in_byte == CH_NL) begin
            flush = 1'b1;
        end else begin
            n_inval = 1'b1;
        end
        if (i_final_req) begin
            flush = 1'b1;
        end

        dec = mcc_pkg::dec_lookup(n_pat, n_len);

        o_job = '0;
        o_push = 1'b0;
        if (!i_direction) begin
            if (i_in_byte == CH_NL) begin
                o_job.kind = mcc_pkg::JOB_NL;
                o_push     = accept;
            end else if (enc.hit) begin
                o_job.kind = enc.slash ? mcc_pkg::JOB_SLASH : mcc_pkg::JOB_SYM;
                o_job.pat  = enc.pat;
                o_job.len  = enc.len;
                o_push     = accept;
            end
        end else if (flush && !n_inval) begin
            o_job.kind = mcc_pkg::JOB_CHAR;
            if (n_slash) begin
                o_job.ch = CH_SPACE;
                o_push   = accept;
            end else if (dec.hit) begin
                o_job.ch = dec.ch;
                o_push   = accept;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat   <= '0;
            r_len   <= '0;
            r_slash <= 1'b0;
            r_inval <= 1'b0;
        end else if (accept && i_direction) begin
            if (flush) begin
                r_pat   <= '0;
                r_len   <= '0;
                r_slash <= 1'b0;
                r_inval <= 1'b0;
            end else begin
                r_pat   <= n_pat;
                r_len   <= n_len;
                r_slash <= n_slash;
                r_inval <= n_inval;
            end
        end
    end

endmodule

>>> rtl/core/mcc_back.sv
// back end: plays queued jobs out as result words through an output register
`timescale 1ns / 1ps

module mcc_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  mcc_pkg::t_job i_job,
    input  logic          i_q_empty,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [2:0]    o_out_kind,
    output logic [7:0]    o_out_char,
    output logic          o_last
);

    localparam int LEN_W = mcc_pkg::LEN_W;
    localparam int IDX_W = $clog2(mcc_pkg::PAT_W);

    logic [LEN_W-1:0] r_idx;
    logic             r_ov;
    logic [2:0]       r_kind;
    logic [7:0]       r_char;
    logic             r_last;

    logic       step;
    logic [2:0] n_kind;
    logic [7:0] n_char;
    logic       n_last;

    assign step  = (!r_ov || i_ready) && !i_q_empty;
    assign o_pop = step && n_last;

    always_comb begin
        n_kind = mcc_pkg::KIND_GAP;
        n_char = '0;
        n_last = 1'b0;
        unique case (i_job.kind)
            mcc_pkg::JOB_SYM: begin
                if (r_idx == i_job.len) begin
                    n_last = 1'b1;
                end else begin
                    n_kind = i_job.pat[r_idx[IDX_W-1:0]] ? mcc_pkg::KIND_DASH
                                                         : mcc_pkg::KIND_DOT;
                end
            end
            mcc_pkg::JOB_SLASH: begin
                if (r_idx == '0) begin
                    n_kind = mcc_pkg::KIND_SLASH;
                end else begin
                    n_last = 1'b1;
                end
            end
            mcc_pkg::JOB_NL: begin
                n_kind = mcc_pkg::KIND_NEWLINE;
                n_last = 1'b1;
            end
            mcc_pkg::JOB_CHAR: begin
                n_kind = mcc_pkg::KIND_CHAR;
                n_char = i_job.ch;
                n_last = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_ov  <= 1'b0;
        end else begin
            if (o_pop) begin
                r_idx <= '0;
            end else if (step) begin
                r_idx <= r_idx + 1'b1;
            end
            if (step) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_kind <= n_kind;
            r_char <= n_char;
            r_last <= n_last;
        end
    end

    assign o_valid    = r_ov;
    assign o_out_kind = r_kind;
    assign o_out_char = r_char;
    assign o_last     = r_last;

endmodule

>>> rtl/core/morse_code_codec.sv
// top level of the morse codec: direction register, front end, job queue, back end
`timescale 1ns / 1ps

// channel   | valid    | ready    | word
// ----------+----------+----------+-----------------------------------
// input     | i_valid  | o_ready  | i_in_byte, i_final_req
// output    | o_valid  | i_ready  | o_out_kind, o_out_char, o_last
// config    | i_cfg_we | (none)   | i_cfg_data (direction)
//
// the front takes one input word per cycle while the job queue has room
// an item yields 0 to 9 result words; the back emits one per cycle while i_ready
// is high, so an encoded character gives code length + 1 words (up to 9)
// reset is synchronous, active low; clears direction, token, queue and output
// the output register lets the front keep filling the queue while i_ready is low

module morse_code_codec (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration
    input  logic       i_cfg_we,
    input  logic       i_cfg_data,
    // input words
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_final_req,
    // result words
    output logic       o_valid,
    input  logic       i_ready,
    output logic [2:0] o_out_kind,
    output logic [7:0] o_out_char,
    output logic       o_last
);

    // direction: 0 encodes text to symbols, 1 decodes symbols to text
    logic r_direction;

    // queue between front and back
    logic          q_push;
    logic          q_pop;
    logic          q_empty;
    logic          q_full;
    mcc_pkg::t_job q_wdata;
    mcc_pkg::t_job q_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction <= 1'b0;
        end else if (i_cfg_we) begin
            r_direction <= i_cfg_data;
        end
    end

    // front: table lookup in encode mode, token collection and match in decode mode
    mcc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_direction (r_direction),
        .i_valid     (i_valid),
        .i_in_byte   (i_in_byte),
        .i_final_req (i_final_req),
        .o_ready     (o_ready),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_job       (q_wdata)
    );

    // only items that give results are queued
    mcc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // back: expands a job into its dot, dash, slash, gap, newline or char words
    mcc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (q_rdata),
        .i_q_empty  (q_empty),
        .o_pop      (q_pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_kind (o_out_kind),
        .o_out_char (o_out_char),
        .o_last     (o_last)
    );

endmodule

>>> rtl/core/mcc_checker.sv
// port-level checks of the morse codec, bound to the top level
`timescale 1ns / 1ps

module mcc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [2:0] o_out_kind,
    input logic [7:0] o_out_char,
    input logic       o_last
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_kind) && $stable(o_out_char)
                                && $stable(o_last))
        else $error("result word changed while stalled");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_out_kind <= mcc_pkg::KIND_CHAR)
        else $error("result kind out of range");

    a_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_kind != mcc_pkg::KIND_CHAR |-> o_out_char == 8'h00)
        else $error("char set on a symbol word");

    // gap, newline and char always close an item; dot, dash and slash never do
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_last == (o_out_kind == mcc_pkg::KIND_GAP
                               || o_out_kind == mcc_pkg::KIND_NEWLINE
                               || o_out_kind == mcc_pkg::KIND_CHAR))
        else $error("last flag disagrees with result kind");

endmodule

bind morse_code_codec mcc_checker u_mcc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_out_kind (o_out_kind),
    .o_out_char (o_out_char),
    .o_last     (o_last)
);
